// File: hw/rtl/lvc_pkg.sv
package lvc_pkg;

    localparam logic [2:0] SHAPE_PARA  = 3'd0;
    localparam logic [2:0] SHAPE_RECT  = 3'd1;
    localparam logic [2:0] SHAPE_RHOMB = 3'd2;
    localparam logic [2:0] SHAPE_HEX   = 3'd3;
    localparam logic [2:0] SHAPE_SQ    = 3'd4;

    // sin(60 deg) in Q31
    localparam logic [31:0] SIN60_Q31 = 32'd1859775393;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 65;
    localparam int CNT_W      = 7;

    localparam logic signed [31:0] FIRST_X_RST  = 32'sd32768000;
    localparam logic signed [31:0] FIRST_Y_RST  = 32'sd0;
    localparam logic signed [31:0] SECOND_X_RST = 32'sd9830400;
    localparam logic signed [31:0] SECOND_Y_RST = -32'sd16384000;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [64:0] num;   // radicand in [63:0] for sqrt
        logic [32:0] den;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] result;
    } iter_rsp_t;

endpackage

// File: hw/rtl/lattice_vector_constrainer.sv
// Lattice basis vector keeper for a tiling cell.
// Input beat (s_*): tdata = {vec_y, vec_x}, each signed Q16.16; tuser = mode
// (0 replaces the first vector, 1 the second). The other vector is then
// re-derived from the shape in cell_shape_sel (written over cfg_wr_en /
// cfg_wr_data; the user writes it only while idle, the block does not enforce it).
// Output beat (m_*): tdata = {second_y, second_x, first_y, first_x}, both vectors
// after the update, saturated Q16.16. One output beat per input beat.
// Path from the accepting edge to the edge that raises m_tvalid:
//   parallelogram / square / unused codes: straight to the final step
//   hexagon: two passes through the shared multiplier
//   rectangle / rhombus: the shared iterative unit runs
//     two 32-step square roots and two 65-step divides, one after another
//     (the divides are skipped when the reference vector is zero).
// Only one beat is in flight: s_tready is high only while the sequencer idles,
// so a new beat is taken only after the last result is loaded for output.
// A finished result sits in the output register; a stalled receiver holds the
// sequencer in its final step, and the next beat can be taken once the result
// register is loaded.
// Reset (aresetn low, synchronous) restores first = (500, 0),
// second = (150, -250), shape = parallelogram, and drops m_tvalid.
module lattice_vector_constrainer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,     // vec_x[31:0], vec_y[63:32]
    input  logic [0:0]   s_tuser,     // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,     // first_x, first_y, second_x, second_y
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data
);
    import lvc_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_A0   = 5'd1;
    localparam logic [4:0] ST_A1   = 5'd2;
    localparam logic [4:0] ST_A2   = 5'd3;
    localparam logic [4:0] ST_A3   = 5'd4;
    localparam logic [4:0] ST_B0   = 5'd5;
    localparam logic [4:0] ST_B1   = 5'd6;
    localparam logic [4:0] ST_B2   = 5'd7;
    localparam logic [4:0] ST_B3   = 5'd8;
    localparam logic [4:0] ST_C0   = 5'd9;
    localparam logic [4:0] ST_C1   = 5'd10;
    localparam logic [4:0] ST_C2   = 5'd11;
    localparam logic [4:0] ST_C3   = 5'd12;
    localparam logic [4:0] ST_C4   = 5'd13;
    localparam logic [4:0] ST_C5   = 5'd14;
    localparam logic [4:0] ST_H0   = 5'd15;
    localparam logic [4:0] ST_H1   = 5'd16;
    localparam logic [4:0] ST_H2   = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    function automatic logic [31:0] mag32(input logic signed [31:0] c);
        return c[31] ? 32'(-c) : 32'(c);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic [4:0]         state_reg, state_next;
    logic [2:0]         shape_reg;
    logic               mode_reg;
    logic [2:0]         cell_shape_sel_reg;
    logic signed [31:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [63:0]        acc_reg, prod_reg;
    logic [31:0]        len_reg, m_reg;
    logic signed [33:0] px_reg, py_reg;
    logic signed [34:0] hx_reg, hy_reg;
    logic               m_tvalid_reg;

    logic [31:0]        mul_a, mul_b;
    logic signed [31:0] new_x, new_y, oth_x, oth_y;
    logic signed [31:0] ha;
    logic               hneg;
    logic [65:0]        hterm, hnum;
    logic signed [34:0] hres;
    logic signed [34:0] ox, oy;
    logic [32:0]        q;
    logic signed [33:0] q_s;
    logic               accept, fin_go;
    iter_req_t          it_req;
    iter_rsp_t          it_rsp;

    assign new_x    = $signed(s_tdata[31:0]);
    assign new_y    = $signed(s_tdata[63:32]);
    assign oth_x    = s_tuser[0] ? fx_reg : sx_reg;
    assign oth_y    = s_tuser[0] ? fy_reg : sy_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sy_reg, sx_reg, fy_reg, fx_reg};
    assign q        = it_rsp.result;

    lvc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (it_req),
        .rsp     (it_rsp)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_A0: begin mul_a = mag32(ax_reg); mul_b = mag32(ax_reg); end
            ST_A1: begin mul_a = mag32(ay_reg); mul_b = mag32(ay_reg); end
            ST_B0: begin mul_a = mag32(bx_reg); mul_b = mag32(bx_reg); end
            ST_B1: begin mul_a = mag32(by_reg); mul_b = mag32(by_reg); end
            ST_C0: begin mul_a = len_reg; mul_b = mag32(bx_reg); end
            ST_C3: begin mul_a = len_reg; mul_b = mag32(by_reg); end
            ST_H0: begin mul_a = mag32(ny_reg); mul_b = SIN60_Q31; end
            ST_H1: begin mul_a = mag32(nx_reg); mul_b = SIN60_Q31; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        it_req.start  = 1'b0;
        it_req.is_div = 1'b0;
        it_req.num    = {1'b0, acc_reg + prod_reg};
        it_req.den    = {m_reg, 1'b0};
        case (state_reg)
            ST_A2, ST_B2: it_req.start = 1'b1;
            ST_C1, ST_C4: begin
                it_req.start  = 1'b1;
                it_req.is_div = 1'b1;
                it_req.num    = {prod_reg, 1'b0} + {33'd0, m_reg};
            end
            default: it_req.start = 1'b0;
        endcase
    end

    // hexagon component: floor((a*2^30 + b*S + 2^30) / 2^31)
    always_comb begin
        if (state_reg == ST_H1) begin
            ha   = nx_reg;
            hneg = mode_reg ? !ny_reg[31] : ny_reg[31];
        end else begin
            ha   = ny_reg;
            hneg = mode_reg ? nx_reg[31] : !nx_reg[31];
        end
        hterm = hneg ? (~{2'b00, prod_reg} + 66'd1) : {2'b00, prod_reg};
        hnum  = ({{34{ha[31]}}, ha} << 30) + hterm + (66'd1 << 30);
        hres  = $signed(hnum[65:31]);
    end

    always_comb begin
        q_s = $signed({1'b0, q});
    end

    always_comb begin
        case (shape_reg)
            SHAPE_RECT: begin
                if (!mode_reg) begin
                    ox = 35'(py_reg);
                    oy = -35'(px_reg);
                end else begin
                    ox = -35'(py_reg);
                    oy = 35'(px_reg);
                end
            end
            SHAPE_RHOMB: begin
                ox = 35'(px_reg);
                oy = 35'(py_reg);
            end
            SHAPE_HEX: begin
                ox = hx_reg;
                oy = hy_reg;
            end
            SHAPE_SQ: begin
                if (!mode_reg) begin
                    ox = 35'(ny_reg);
                    oy = -35'(nx_reg);
                end else begin
                    ox = -35'(ny_reg);
                    oy = 35'(nx_reg);
                end
            end
            default: begin
                ox = mode_reg ? 35'(fx_reg) : 35'(sx_reg);
                oy = mode_reg ? 35'(fy_reg) : 35'(sy_reg);
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cell_shape_sel_reg == SHAPE_RECT ||
                        cell_shape_sel_reg == SHAPE_RHOMB) begin
                        state_next = ST_A0;
                    end else if (cell_shape_sel_reg == SHAPE_HEX) begin
                        state_next = ST_H0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_A0: state_next = ST_A1;
            ST_A1: state_next = ST_A2;
            ST_A2: state_next = ST_A3;
            ST_A3: if (it_rsp.done) state_next = ST_B0;
            ST_B0: state_next = ST_B1;
            ST_B1: state_next = ST_B2;
            ST_B2: state_next = ST_B3;
            ST_B3: begin
                if (it_rsp.done) begin
                    state_next = (bx_reg == 0 && by_reg == 0) ? ST_FIN : ST_C0;
                end
            end
            ST_C0: state_next = ST_C1;
            ST_C1: state_next = ST_C2;
            ST_C2: if (it_rsp.done) state_next = ST_C3;
            ST_C3: state_next = ST_C4;
            ST_C4: state_next = ST_C5;
            ST_C5: if (it_rsp.done) state_next = ST_FIN;
            ST_H0: state_next = ST_H1;
            ST_H1: state_next = ST_H2;
            ST_H2: state_next = ST_FIN;
            ST_FIN: if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
            cell_shape_sel_reg <= SHAPE_PARA;
            fx_reg             <= FIRST_X_RST;
            fy_reg             <= FIRST_Y_RST;
            sx_reg             <= SECOND_X_RST;
            sy_reg             <= SECOND_Y_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cell_shape_sel_reg <= cfg_wr_data;
            end
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
                if (!mode_reg) begin
                    fx_reg <= nx_reg;
                    fy_reg <= ny_reg;
                    sx_reg <= sat32(36'(ox));
                    sy_reg <= sat32(36'(oy));
                end else begin
                    sx_reg <= nx_reg;
                    sy_reg <= ny_reg;
                    fx_reg <= sat32(36'(ox));
                    fy_reg <= sat32(36'(oy));
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_reg  <= s_tuser[0];
                    shape_reg <= cell_shape_sel_reg;
                    nx_reg    <= new_x;
                    ny_reg    <= new_y;
                    if (cell_shape_sel_reg == SHAPE_RECT) begin
                        ax_reg <= oth_x;
                        ay_reg <= oth_y;
                        bx_reg <= new_x;
                        by_reg <= new_y;
                    end else begin
                        ax_reg <= new_x;
                        ay_reg <= new_y;
                        bx_reg <= oth_x;
                        by_reg <= oth_y;
                    end
                end
            end
            ST_A1, ST_B1: acc_reg <= prod_reg;
            ST_A3: if (it_rsp.done) len_reg <= q[31:0];
            ST_B3: begin
                if (it_rsp.done) begin
                    m_reg  <= q[31:0];
                    // zero reference points along +x
                    px_reg <= $signed({2'b00, len_reg});
                    py_reg <= '0;
                end
            end
            ST_C2: if (it_rsp.done) px_reg <= bx_reg[31] ? -q_s : q_s;
            ST_C5: if (it_rsp.done) py_reg <= by_reg[31] ? -q_s : q_s;
            ST_H1: hx_reg <= hres;
            ST_H2: hy_reg <= hres;
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/lvc_iter.sv
module lvc_iter (
    input  logic               aclk,
    input  logic               aresetn,
    input  lvc_pkg::iter_req_t req,
    output lvc_pkg::iter_rsp_t rsp
);
    import lvc_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             is_div_reg;
    logic [CNT_W-1:0] cnt_reg;
    // sqrt
    logic [63:0]      op_reg;
    logic [63:0]      res_reg;
    logic [63:0]      bit_reg;
    // divide: quotient shifts into num_reg
    logic [64:0]      num_reg;
    logic [33:0]      rem_reg;
    logic [32:0]      den_reg;

    logic [63:0]      trial;
    logic [33:0]      rem_sh;
    logic             last;

    assign trial  = res_reg + bit_reg;
    assign rem_sh = {rem_reg[32:0], num_reg[64]};
    assign last   = is_div_reg ? (cnt_reg == CNT_W'(DIV_STEPS - 1))
                               : (cnt_reg == CNT_W'(SQRT_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            is_div_reg <= req.is_div;
            cnt_reg    <= '0;
            op_reg     <= req.num[63:0];
            res_reg    <= '0;
            bit_reg    <= 64'd1 << 62;
            num_reg    <= req.num;
            rem_reg    <= '0;
            den_reg    <= req.den;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (is_div_reg) begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    num_reg <= {num_reg[63:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    num_reg <= {num_reg[63:0], 1'b0};
                end
            end else begin
                if (op_reg >= trial) begin
                    op_reg  <= op_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    always_comb begin
        rsp.done = done_reg;
        if (is_div_reg) begin
            rsp.result = num_reg[32:0];
        end else begin
            // round to nearest
            rsp.result = res_reg[32:0] + 33'(op_reg > res_reg);
        end
    end

endmodule

// File: hw/rtl/lvc_checker.sv
module lvc_sva (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // one beat in flight
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind lattice_vector_constrainer lvc_sva u_lvc_sva (.*);

// File: tb/lvc_checker.sv
`timescale 1ns / 100ps

module lvc_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,
    output int           fail_count,
    output int           pending
);
    import lvc_pkg::*;

    logic [2:0]      shape;
    longint          fx, fy, sx, sy;
    logic [127:0]    expected_vecs[$];

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint absv(longint c);
        return (c < 0) ? -c : c;
    endfunction

    // integer sqrt rounded to nearest, ties up
    function automatic longint isqrt_rnd(logic [63:0] s);
        logic [63:0] op, res, b;
        op = s; res = 0; b = 64'd1 << 62;
        while (b > op) b = b >> 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op = op - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        if (op > res) res = res + 1;
        return longint'(res);
    endfunction

    function automatic longint norm(longint x, longint y);
        logic [63:0] ax, ay;
        ax = absv(x); ay = absv(y);
        return isqrt_rnd(ax * ax + ay * ay);
    endfunction

    function automatic longint scale_comp(longint len, longint c, longint m);
        logic [127:0] q;
        q = (128'(2) * len * absv(c) + m) / (128'(2) * m);
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void point_along(longint len, longint rx, longint ry,
                                        output longint ox, output longint oy);
        longint m;
        m = norm(rx, ry);
        if (rx == 0 && ry == 0) begin
            ox = len; oy = 0;
        end else begin
            ox = scale_comp(len, rx, m);
            oy = scale_comp(len, ry, m);
        end
    endfunction

    // (a*2^30 + b*sin60) / 2^31, ties toward +inf
    function automatic longint turn60(longint a, longint b);
        logic signed [95:0] n;
        n = 96'(a) * (96'sd1 <<< 30) + 96'(b) * 96'sd1859775393 + (96'sd1 <<< 30);
        return longint'(n >>> 31);
    endfunction

    function automatic void rederive(logic turn_pos, longint nx, longint ny,
                                     inout longint ox, inout longint oy);
        longint px, py;
        case (shape)
            SHAPE_RECT: begin
                point_along(norm(ox, oy), nx, ny, px, py);
                if (!turn_pos) begin ox = py; oy = -px; end
                else begin ox = -py; oy = px; end
            end
            SHAPE_RHOMB: begin
                point_along(norm(nx, ny), ox, oy, px, py);
                ox = px; oy = py;
            end
            SHAPE_HEX: begin
                if (!turn_pos) begin
                    ox = turn60(nx, ny); oy = turn60(ny, -nx);
                end else begin
                    ox = turn60(nx, -ny); oy = turn60(ny, nx);
                end
            end
            SHAPE_SQ: begin
                if (!turn_pos) begin ox = ny; oy = -nx; end
                else begin ox = -ny; oy = nx; end
            end
            default: ;
        endcase
        ox = sat(ox);
        oy = sat(oy);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        longint nx, ny;
        logic [127:0] want;
        if (!aresetn) begin
            shape <= SHAPE_PARA;
            fx = 64'sd32768000; fy = 0; sx = 64'sd9830400; sy = -64'sd16384000;
            expected_vecs.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) shape <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                nx = longint'($signed(s_tdata[31:0]));
                ny = longint'($signed(s_tdata[63:32]));
                if (!s_tuser[0]) begin
                    fx = nx; fy = ny;
                    rederive(1'b0, nx, ny, sx, sy);
                end else begin
                    sx = nx; sy = ny;
                    rederive(1'b1, nx, ny, fx, fy);
                end
                want = {sy[31:0], sx[31:0], fy[31:0], fx[31:0]};
                expected_vecs = {expected_vecs, want};
            end
            if (m_tvalid && m_tready) begin
                if (expected_vecs.size() == 0) begin
                    report("unexpected beat", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_vecs.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                        report("first_x", m_tdata[31:0], want[31:0]);
                    if (m_tdata[63:32] !== want[63:32])
                        report("first_y", m_tdata[63:32], want[63:32]);
                    if (m_tdata[95:64] !== want[95:64])
                        report("second_x", m_tdata[95:64], want[95:64]);
                    if (m_tdata[127:96] !== want[127:96])
                        report("second_y", m_tdata[127:96], want[127:96]);
                end
            end
        end
        pending = expected_vecs.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lvc_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = 0;
    logic [0:0]   s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_wr_data = 0;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           no_gaps = 0;
    bit           hold_rx = 0;
    logic [2:0]   codes[8] = '{SHAPE_PARA, SHAPE_RECT, SHAPE_RHOMB, SHAPE_HEX,
                               SHAPE_SQ, 3'd5, 3'd6, 3'd7};

    always #5 aclk = ~aclk;

    lattice_vector_constrainer u_dut (.*);

    lvc_checker u_chk (.*);

    // receiver: random stalls, plus a long hold while hold_rx is set
    always @(negedge aclk) begin
        if (!aresetn || hold_rx) m_tready <= 0;
        else m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 36);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(2000)) - 1000) <<< 16;
            3: return $urandom_range(255) - 128;
            4: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // s_tvalid stays up after a beat until the next step decides it
    task automatic send_beat(logic mode, logic [31:0] vx, logic [31:0] vy);
        while (!no_gaps && $urandom_range(99) < 36) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic set_shape(logic [2:0] code);
        drain();
        cfg_wr_en   <= 1;
        cfg_wr_data <= code;
        @(negedge aclk);
        cfg_wr_en   <= 0;
    endtask

    task automatic directed_set();
        send_beat(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(1'b0, 32'h0, 32'h0);
        send_beat(1'b1, 32'h0, 32'h0);
        send_beat(1'b0, 32'h0064_0000, 32'hffce_0000);
        send_beat(1'b1, 32'hff9c_0000, 32'h0032_0000);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // reset state first, then every shape code including unused ones
        send_beat(1'b1, 32'h0010_0000, 32'h0020_0000);
        foreach (codes[i]) begin
            set_shape(codes[i]);
            directed_set();
        end
        // long receiver hold while the sender keeps offering
        fork
            begin
                hold_rx = 1;
                repeat (600) @(negedge aclk);
                hold_rx = 0;
            end
            repeat (4) send_beat(1'($urandom_range(1)), rand_comp(), rand_comp());
        join
        for (int ph = 0; ph < 12; ph++) begin
            set_shape((ph < 10) ? codes[ph % 5] : codes[5 + ph % 3]);
            no_gaps = (ph == 3);
            repeat (50) send_beat(1'($urandom_range(1)), rand_comp(), rand_comp());
        end
        no_gaps = 0;
        drain();
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lvc_pkg.sv
hw/rtl/lvc_iter.sv
hw/rtl/lattice_vector_constrainer.sv
hw/rtl/lvc_checker.sv
tb/lvc_checker.sv
tb/testbench.sv
